[rtl/assert_macros.svh]
// Assertion macros for the RTL files of the KMP stream matcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define KMP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Checks that a condition implies a property in the same cycle.
`define KMP_ASSERT_IMP(label, cond, prop, msg) \
   `KMP_ASSERT(label, (cond) |-> (prop), msg)

// Checks that a condition implies a property in the next cycle.
`define KMP_ASSERT_NEXT(label, cond, prop, msg) \
   `KMP_ASSERT(label, (cond) |=> (prop), msg)

`endif

[rtl/kmp_pkg.sv]
// Package with the codes, types and helpers of the KMP stream matcher.
`timescale 1ns / 1ps
`default_nettype none

package kmp_pkg;

   localparam int MAX_PATTERN_DEF   = 64;
   localparam int SYMBOL_BITS_DEF   = 8;
   localparam int POSITION_BITS_DEF = 32;

   localparam logic [1:0] OP_CLEAR   = 2'd0;
   localparam logic [1:0] OP_APPEND  = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;
   localparam logic [1:0] OP_TEXT    = 2'd3;

   localparam logic [1:0] MODE_OVERLAP = 2'd0;
   localparam logic [1:0] MODE_RESTART = 2'd1;
   localparam logic [1:0] MODE_FIRST   = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic        match;
      logic [31:0] match_start;
      logic [31:0] match_count;
      logic [1:0]  status;
   } rsp_type;

   function automatic int addr_bits(input int depth);
      addr_bits = (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

`default_nettype wire

[rtl/kmp_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module kmp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [kmp_pkg::addr_bits(DEPTH)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic [kmp_pkg::addr_bits(DEPTH)-1:0]  rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);
   import kmp_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en && (int'(wr_addr) < DEPTH)) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/kmp_stream_matcher_core.sv]
// Top level of the streaming Knuth-Morris-Pratt matcher.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// The pattern symbols and their failure entries live in two synchronous
// memories that share one read index, and one request is worked on at a
// time. A text symbol passes through the look state, which repeats for
// every failure fallback it needs, since each fallback step waits on the
// registered read of both memories. An append to a non-empty, non-full
// pattern also searches there, and its search always starts with one step
// from the old length to that length's failure entry. Clear, restart, an
// append to an empty or full store and a text symbol with an empty pattern
// finish on acceptance without a search. The next request transfers while
// a result still waits at the output, but a second finished result is held
// until the first one has been taken.

module kmp_stream_matcher_core #(
   parameter int MAX_PATTERN   = kmp_pkg::MAX_PATTERN_DEF,
   parameter int SYMBOL_BITS   = kmp_pkg::SYMBOL_BITS_DEF,
   parameter int POSITION_BITS = kmp_pkg::POSITION_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [1:0]             csr_wr_data,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [1:0]             req_operation,
   input  wire logic [SYMBOL_BITS-1:0] req_symbol,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_match,
   output logic [31:0]                 rsp_match_start,
   output logic [31:0]                 rsp_match_count,
   output logic [1:0]                  rsp_status
);
   import kmp_pkg::*;

   localparam int IDX_BITS = addr_bits(MAX_PATTERN + 1);
   localparam int PAT_BITS = addr_bits(MAX_PATTERN);
   localparam int CMP_BITS = (POSITION_BITS > IDX_BITS) ? POSITION_BITS : IDX_BITS;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOOK = 2'd1;
   localparam logic [1:0] ST_PUSH = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic [1:0]               mode_ff, mode_in;
   logic [IDX_BITS-1:0]      plen_ff, plen_in;
   logic [IDX_BITS-1:0]      mpre_ff, mpre_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [31:0]              count_ff, count_in;
   logic                     first_ff, first_in;
   logic [IDX_BITS-1:0]      j_ff, j_in;
   logic                     append_ff, append_in;
   logic [SYMBOL_BITS-1:0]   sym_ff, sym_in;
   rsp_type                  pend_ff, pend_in;
   rsp_type                  rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic                     ps_we;
   logic [PAT_BITS-1:0]      ps_waddr;
   logic [SYMBOL_BITS-1:0]   ps_rd;
   logic                     ft_we;
   logic [IDX_BITS-1:0]      ft_waddr;
   logic [IDX_BITS-1:0]      ft_wdata;
   logic [IDX_BITS-1:0]      ft_rd;

   logic                     accept;
   logic                     out_free;
   logic                     fall;
   logic [IDX_BITS-1:0]      j_final;
   logic                     full_hit;
   logic                     report;
   logic [CMP_BITS-1:0]      pos_w;
   logic [CMP_BITS-1:0]      nm1_w;
   logic [CMP_BITS-1:0]      start_w;
   logic                     res_en;
   rsp_type                  res;

   kmp_ram #(
      .WIDTH (SYMBOL_BITS),
      .DEPTH (MAX_PATTERN)
   ) u_pattern_ram (
      .clock   (clock),
      .wr_en   (ps_we),
      .wr_addr (ps_waddr),
      .wr_data (req_symbol),
      .rd_addr (j_in[PAT_BITS-1:0]),
      .rd_data (ps_rd)
   );

   kmp_ram #(
      .WIDTH (IDX_BITS),
      .DEPTH (MAX_PATTERN + 1)
   ) u_failure_ram (
      .clock   (clock),
      .wr_en   (ft_we),
      .wr_addr (ft_waddr),
      .wr_data (ft_wdata),
      .rd_addr (j_in),
      .rd_data (ft_rd)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign fall     = (j_ff != '0) && ((j_ff == plen_ff) || (ps_rd != sym_ff));
   assign j_final  = ((j_ff < plen_ff) && (ps_rd == sym_ff)) ? j_ff + IDX_BITS'(1) : j_ff;
   assign full_hit = (j_final == plen_ff);
   assign report   = full_hit && !((mode_ff == MODE_FIRST) && first_ff);
   assign pos_w    = CMP_BITS'(pos_ff);
   assign nm1_w    = CMP_BITS'(plen_ff) - CMP_BITS'(1);
   assign start_w  = (pos_w >= nm1_w) ? pos_w - nm1_w : '0;

   always_comb begin
      state_in  = state_ff;
      mode_in   = csr_wr_en ? csr_wr_data : mode_ff;
      plen_in   = plen_ff;
      mpre_in   = mpre_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      first_in  = first_ff;
      j_in      = j_ff;
      append_in = append_ff;
      sym_in    = sym_ff;
      pend_in   = pend_ff;
      ps_we     = 1'b0;
      ps_waddr  = plen_ff[PAT_BITS-1:0];
      ft_we     = 1'b0;
      ft_waddr  = plen_ff + IDX_BITS'(1);
      ft_wdata  = '0;
      res_en    = 1'b0;
      res       = '{match: 1'b0, match_start: 32'd0, match_count: count_ff,
                    status: STATUS_OK};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sym_in = req_symbol;
               unique case (req_operation) inside
                  OP_CLEAR, OP_RESTART: begin
                     if (req_operation == OP_CLEAR) begin
                        plen_in = '0;
                     end
                     mpre_in         = '0;
                     pos_in          = '0;
                     count_in        = '0;
                     first_in        = 1'b0;
                     res.match_count = 32'd0;
                     res_en          = 1'b1;
                  end
                  OP_APPEND: begin
                     if (plen_ff == IDX_BITS'(MAX_PATTERN)) begin
                        res.status = STATUS_FULL;
                        res_en     = 1'b1;
                     end else if (plen_ff == '0) begin
                        ps_we   = 1'b1;
                        ft_we   = 1'b1;
                        plen_in = IDX_BITS'(1);
                        res_en  = 1'b1;
                     end else begin
                        ps_we     = 1'b1;
                        j_in      = plen_ff;
                        append_in = 1'b1;
                        state_in  = ST_LOOK;
                     end
                  end
                  OP_TEXT: begin
                     if (plen_ff == '0) begin
                        res.status = STATUS_EMPTY;
                        res_en     = 1'b1;
                     end else begin
                        j_in      = mpre_ff;
                        append_in = 1'b0;
                        state_in  = ST_LOOK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOOK: begin
            if (fall) begin
               j_in = ft_rd;
            end else begin
               res_en = 1'b1;
               if (append_ff) begin
                  ft_we    = 1'b1;
                  ft_wdata = j_final;
                  plen_in  = plen_ff + IDX_BITS'(1);
               end else begin
                  mpre_in = (full_hit && (mode_ff == MODE_RESTART)) ? '0 : j_final;
                  if (pos_ff != '1) begin
                     pos_in = pos_ff + POSITION_BITS'(1);
                  end
                  if (report) begin
                     first_in        = 1'b1;
                     count_in        = (count_ff != '1) ? count_ff + 32'd1 : count_ff;
                     res.match       = 1'b1;
                     res.match_start = 32'(start_w);
                     res.match_count = count_in;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (res_en && !out_free) begin
         pend_in  = res;
         state_in = ST_PUSH;
      end

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_free && (res_en || (state_ff == ST_PUSH))) begin
         rsp_in       = (state_ff == ST_PUSH) ? pend_ff : res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_OVERLAP;
         plen_ff      <= '0;
         mpre_ff      <= '0;
         pos_ff       <= '0;
         count_ff     <= '0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         plen_ff      <= plen_in;
         mpre_ff      <= mpre_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff      <= j_in;
      append_ff <= append_in;
      sym_ff    <= sym_in;
      pend_ff   <= pend_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match       = rsp_ff.match;
   assign rsp_match_start = rsp_ff.match_start;
   assign rsp_match_count = rsp_ff.match_count;
   assign rsp_status      = rsp_ff.status;

   `KMP_ASSERT(a_prefix_in_range, mpre_ff <= plen_ff, "matched prefix exceeds pattern length")
   `KMP_ASSERT_IMP(a_look_index, state_ff == ST_LOOK, j_ff <= plen_ff,
                   "fallback index exceeds pattern length")
   `KMP_ASSERT_IMP(a_push_waits, state_ff == ST_PUSH, rsp_valid_ff,
                   "held result without an occupied output")
   `KMP_ASSERT_NEXT(a_count_after_hit, (state_ff == ST_LOOK) && !fall && !append_ff && report,
                    count_ff != 32'd0, "reported match left the count at zero")

endmodule

`default_nettype wire
